@@ design/bpv_pkg.sv @@
// Package for the bond partial volume core: shared widths, register indexes,
// the bond class code and the sideband that rides along the cell chains.
// No dependencies.
package bpv_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REG_W   = 31;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned REM_W   = 34;
  localparam int unsigned VOL_W   = 34;

  localparam logic [VOL_W-1:0] VOL_CAP     = 34'h2_0000_0000;
  localparam logic [REG_W-1:0] REG_ONE_RST = 31'd65536;

  localparam logic [IDX_W-1:0] REG_HORIZON = 2'd0;
  localparam logic [IDX_W-1:0] REG_BAND    = 2'd1;
  localparam logic [IDX_W-1:0] REG_GRID    = 2'd2;

  typedef enum logic [1:0] {
    CLS_OUT,
    CLS_FULL,
    CLS_BAND
  } cls_e;

  typedef struct packed {
    logic valid;
    logic r_zero;
    cls_e cls;
  } side_t;

endpackage

@@ design/bpv_if.sv @@
// Handshake channels of the bond partial volume core: input item, result item
// and configuration write. Depends on bpv_pkg.
interface bpv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] neighbor_x;
  logic signed [31:0] neighbor_y;
  logic signed [31:0] neighbor_z;
  modport source (output valid, center_x, center_y, center_z,
                  neighbor_x, neighbor_y, neighbor_z, input ready);
  modport sink (input valid, center_x, center_y, center_z,
                neighbor_x, neighbor_y, neighbor_z, output ready);
endinterface

interface bpv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bond_volume;
  logic        volume_saturated;
  modport source (output valid, bond_volume, volume_saturated, input ready);
  modport sink (input valid, bond_volume, volume_saturated, output ready);
endinterface

interface bpv_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bpv_pkg::IDX_W-1:0]   reg_index;
  logic [bpv_pkg::DATA_W-1:0]  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ design/bpv_sqrt_cell.sv @@
// One digit cell of the square root chain: resolves one root bit per stage.
// Depends on bpv_pkg.
module bpv_sqrt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  bpv_pkg::side_t               side_i,
  input  logic [bpv_pkg::REM_W-1:0]    rem_i,
  input  logic [bpv_pkg::ROOT_W-1:0]   root_i,
  input  logic [bpv_pkg::SQ_W-1:0]     rad_i,
  output bpv_pkg::side_t               side_o,
  output logic [bpv_pkg::REM_W-1:0]    rem_o,
  output logic [bpv_pkg::ROOT_W-1:0]   root_o,
  output logic [bpv_pkg::SQ_W-1:0]     rad_o
);
  import bpv_pkg::*;

  logic [REM_W+1:0] cur, trial;
  logic             ge;
  side_t            side_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q;
  logic [SQ_W-1:0]  rad_q;

  // Bring down the next two radicand bits and try the digit one.
  assign cur   = {rem_i, rad_i[SQ_W-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = cur >= trial;
  assign rem_d = ge ? REM_W'(cur - trial) : REM_W'(cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= {root_i[ROOT_W-2:0], ge};
      rad_q  <= {rad_i[SQ_W-3:0], 2'b00};
    end
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
endmodule

@@ design/bpv_div_cell.sv @@
// One cell of the restoring divider chain: resolves one quotient bit per stage.
// Depends on bpv_pkg.
module bpv_div_cell #(
  parameter int unsigned NW = 47
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [bpv_pkg::DATA_W-1:0]    den_i,
  input  bpv_pkg::side_t                side_i,
  input  logic [bpv_pkg::DATA_W-1:0]    rem_i,
  input  logic [NW-1:0]                 num_i,
  input  logic [NW-1:0]                 quo_i,
  output bpv_pkg::side_t                side_o,
  output logic [bpv_pkg::DATA_W-1:0]    rem_o,
  output logic [NW-1:0]                 num_o,
  output logic [NW-1:0]                 quo_o
);
  import bpv_pkg::*;

  logic [DATA_W:0]   cur, diff;
  logic              ge;
  side_t             side_q;
  logic [DATA_W-1:0] rem_q;
  logic [NW-1:0]     num_q, quo_q;

  assign cur  = {rem_i, num_i[NW-1]};
  assign diff = cur - {1'b0, den_i};
  assign ge   = cur >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? diff[DATA_W-1:0] : cur[DATA_W-1:0];
      num_q <= {num_i[NW-2:0], 1'b0};
      quo_q <= {quo_i[NW-2:0], ge};
    end
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign quo_o  = quo_q;
endmodule

@@ design/bpv_cube.sv @@
// Full cell volume from the grid spacing register: floor(g^3 / 2^(2F)),
// clipped at VOL_CAP, over three register stages. Depends on bpv_pkg.
module bpv_cube #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic [bpv_pkg::REG_W-1:0]   grid_i,
  output logic [bpv_pkg::VOL_W-1:0]   full_o
);
  import bpv_pkg::*;

  localparam int unsigned GG_W = 2 * REG_W;
  localparam int unsigned TW   = 3 * REG_W;

  logic [GG_W-1:0]        gg_q;
  logic [REG_W+31:0]      plo_q;
  logic [GG_W-32+REG_W-1:0] phi_q;
  logic [TW-1:0]          total, shr;
  logic [VOL_W-1:0]       full_q;

  assign total = (TW'(phi_q) << 32) + TW'(plo_q);
  assign shr   = total >> (2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    gg_q   <= grid_i * grid_i;
    plo_q  <= gg_q[31:0] * grid_i;
    phi_q  <= gg_q[GG_W-1:32] * grid_i;
    full_q <= (shr > TW'(VOL_CAP)) ? VOL_CAP : shr[VOL_W-1:0];
  end

  assign full_o = full_q;
endmodule

@@ design/bond_partial_volume_core.sv @@
// Coordinates carry FRAC_BITS fraction bits (Q16.16 at the default).
// Throughput: one item per cycle; the square root and divider chains of cells
// each resolve one bit per stage, and the whole pipe stalls only on the output.
// Reset: rst_ni clears all valid flags and loads horizon 1.0, band width 0 and
// grid spacing 1.0; the cell volume settles once a write has passed bpv_cube.
module bond_partial_volume_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpv_in_if.sink     in_i,
  bpv_cfg_if.sink    cfg_i,
  bpv_out_if.source  out_o
);
  import bpv_pkg::*;

  // Numerator and quotient width of the band coefficient division.
  localparam int unsigned NW   = REG_W + FRAC_BITS;
  // Coefficient width, split in two halves for the final multiply.
  localparam int unsigned CW   = 32 + FRAC_BITS;
  localparam int unsigned LOW  = CW / 2;
  localparam int unsigned HIW  = CW - LOW;
  localparam int unsigned PW   = VOL_W + CW;
  localparam int unsigned VW   = PW - FRAC_BITS;
  localparam logic [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);

  // Configuration registers. The user must write only while the pipe is empty.
  logic [REG_W-1:0] horizon_q, band_q, grid_q;
  logic [VOL_W-1:0] full_vol;
  logic [DATA_W-1:0] den;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= REG_ONE_RST;
      band_q    <= '0;
      grid_q    <= REG_ONE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_HORIZON: horizon_q <= cfg_i.wdata[REG_W-1:0];
        REG_BAND:    band_q    <= cfg_i.wdata[REG_W-1:0];
        REG_GRID:    grid_q    <= cfg_i.wdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  bpv_cube #(.FRAC_BITS(FRAC_BITS)) u_cube (
    .clk_i  (clk_i),
    .grid_i (grid_q),
    .full_o (full_vol)
  );

  // The divisor is 2 * band width; the user keeps it constant while items flow.
  assign den = {band_q, 1'b0};

  // All stages move together; the output register parts the two sides.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: axis differences and their magnitudes. A magnitude of 2^31 or
  // more puts the bond beyond any horizon, so it is marked outside at once.
  logic signed [DATA_W:0] diff [3];
  logic [DATA_W:0]        mag [3];
  logic [REG_W-1:0]       ax_q [3];
  logic [REG_W-1:0]       ax_d [3];
  side_t                  s1_q, s1_d;
  logic                   far;

  assign diff[0] = {in_i.neighbor_x[31], in_i.neighbor_x} - {in_i.center_x[31], in_i.center_x};
  assign diff[1] = {in_i.neighbor_y[31], in_i.neighbor_y} - {in_i.center_y[31], in_i.center_y};
  assign diff[2] = {in_i.neighbor_z[31], in_i.neighbor_z} - {in_i.center_z[31], in_i.center_z};

  always_comb begin
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag[i]  = diff[i][DATA_W] ? (DATA_W+1)'(0) - diff[i] : diff[i];
      ax_d[i] = mag[i][REG_W-1:0];
      far     = far | (|mag[i][DATA_W:REG_W]);
    end
    s1_d.valid  = in_i.valid;
    s1_d.r_zero = 1'b0;
    s1_d.cls    = far ? CLS_OUT : CLS_FULL;
  end

  // Stage 2: squares. Stage 3: sum of squares, the radicand.
  logic [2*REG_W-1:0] sq_q [3];
  logic [SQ_W-1:0]    sum_q;
  side_t              s2_q, s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ax_q[i] <= ax_d[i];
        sq_q[i] <= ax_q[i] * ax_q[i];
      end
      sum_q <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
    end
  end

  // Square root chain: one cell per root bit, two radicand bits each.
  side_t             sq_side [ROOT_W+1];
  logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [SQ_W-1:0]   sq_rad  [ROOT_W+1];

  assign sq_side[0] = s3_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = sum_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    bpv_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .side_i (sq_side[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .side_o (sq_side[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .rad_o  (sq_rad[k+1])
    );
  end

  // Band stage: classify the distance against the horizon and the band.
  // Inside when d + r < h, in the band when d <= h <= d + r, else outside.
  logic [ROOT_W-1:0] distance;
  logic [ROOT_W:0]   reach;
  logic              le_h, in_band;
  logic [REG_W-1:0]  hd;
  side_t             bd_side_q, bd_side_d;
  logic [NW-1:0]     bd_num_q;

  assign distance = sq_root[ROOT_W];
  assign le_h     = distance <= {1'b0, horizon_q};
  assign reach    = {1'b0, distance} + {2'b00, band_q};
  assign in_band  = reach >= {2'b00, horizon_q};
  assign hd       = horizon_q - distance[REG_W-1:0];

  always_comb begin
    bd_side_d        = sq_side[ROOT_W];
    bd_side_d.r_zero = (band_q == '0);
    if (sq_side[ROOT_W].cls != CLS_OUT) begin
      if (!le_h) begin
        bd_side_d.cls = CLS_OUT;
      end else if (in_band) begin
        bd_side_d.cls = CLS_BAND;
      end else begin
        bd_side_d.cls = CLS_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bd_side_q <= '0;
    end else if (adv) begin
      bd_side_q <= bd_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bd_num_q <= {hd, {FRAC_BITS{1'b0}}};
    end
  end

  // Divider chain: (h - d) * 2^F / (2r), one quotient bit per cell.
  side_t             dv_side [NW+1];
  logic [DATA_W-1:0] dv_rem  [NW+1];
  logic [NW-1:0]     dv_num  [NW+1];
  logic [NW-1:0]     dv_quo  [NW+1];

  assign dv_side[0] = bd_side_q;
  assign dv_rem[0]  = '0;
  assign dv_num[0]  = bd_num_q;
  assign dv_quo[0]  = '0;

  for (genvar k = 0; k < NW; k++) begin : g_div
    bpv_div_cell #(.NW(NW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .den_i  (den),
      .side_i (dv_side[k]),
      .rem_i  (dv_rem[k]),
      .num_i  (dv_num[k]),
      .quo_i  (dv_quo[k]),
      .side_o (dv_side[k+1]),
      .rem_o  (dv_rem[k+1]),
      .num_o  (dv_num[k+1]),
      .quo_o  (dv_quo[k+1])
    );
  end

  // Product stage: the coefficient is one half plus the quotient, or exactly
  // one half when the band width is zero. Two partial products of the volume.
  logic [CW-1:0]        coef;
  side_t                p_side_q;
  logic [VOL_W+LOW-1:0] plo_q;
  logic [VOL_W+HIW-1:0] phi_q;

  assign coef = HALF + (dv_side[NW].r_zero ? CW'(0) : CW'(dv_quo[NW]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_side_q <= '0;
    end else if (adv) begin
      p_side_q <= dv_side[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q <= full_vol * coef[LOW-1:0];
      phi_q <= full_vol * coef[CW-1:LOW];
    end
  end

  // Output stage: join the partial products, pick by class and saturate.
  logic [PW-1:0] prod;
  logic [VW-1:0] vol;
  logic          sat;
  logic [31:0]   out_vol_q;
  logic          out_sat_q;

  assign prod = (PW'(phi_q) << LOW) + PW'(plo_q);

  always_comb begin
    case (p_side_q.cls)
      CLS_BAND: vol = prod[PW-1:FRAC_BITS];
      CLS_FULL: vol = VW'(full_vol);
      default:  vol = '0;
    endcase
    sat = |vol[VW-1:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p_side_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_vol_q <= sat ? '1 : vol[31:0];
      out_sat_q <= sat;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.bond_volume      = out_vol_q;
  assign out_o.volume_saturated = out_sat_q;

`ifndef ASSERT_OFF
  // A clipped result always reads as the largest volume.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.volume_saturated |-> out_o.bond_volume == '1)
    else $error("saturated result does not hold the maximum volume");

  // A stalled output freezes the divider chain's last stage.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_side[NW]))
    else $error("pipeline moved while the output was stalled");

  // The output valid follows the product stage whenever the pipe advances.
  a_valid_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q == $past(p_side_q.valid))
    else $error("output valid lost or invented an item");
`endif
endmodule

@@ test/bpv_checker.sv @@
// Scoreboard for the bond partial volume core: predicts each result from the
// accepted input items and configuration writes, and compares it with the output.
// Depends on bpv_pkg and the channel interfaces in bpv_if.sv.
module bpv_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bpv_in_if    in_if,
  bpv_cfg_if   cfg_if,
  bpv_out_if   out_if,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpv_pkg::*;

  typedef struct packed {
    logic [31:0] bond_volume;
    logic        volume_saturated;
  } volume_t;

  logic [REG_W-1:0] horizon_q, band_q, grid_q;
  volume_t          expected_volumes[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root, bit_q;
    root  = '0;
    bit_q = 64'd1 << 62;
    while (bit_q > n) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (n >= root + bit_q) begin
        n    = n - (root + bit_q);
        root = (root >> 1) + bit_q;
      end else begin
        root = root >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return root;
  endfunction

  // Corrected neighbor volume of one bond under the current registers.
  function automatic volume_t bond_volume_of(input logic signed [31:0] c[3],
                                             input logic signed [31:0] n[3]);
    volume_t      res;
    logic [63:0]  sum_sq, mag;
    longint       diff, distance, h, r, lo;
    logic [95:0]  g3;
    logic [127:0] full, coef, vol;
    bit           far;
    sum_sq = '0;
    far    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff = longint'(n[i]) - longint'(c[i]);
      mag  = diff < 0 ? -diff : diff;
      if (mag >= 64'h8000_0000) far = 1'b1;
      else sum_sq = sum_sq + mag * mag;
    end
    vol = '0;
    if (!far) begin
      distance = longint'(int_sqrt(sum_sq));
      h        = longint'(horizon_q);
      r        = longint'(band_q);
      lo       = h - r;
      g3   = 96'(grid_q) * 96'(grid_q) * 96'(grid_q);
      full = 128'(g3 >> (2 * FRAC_BITS));
      if (full > 128'(VOL_CAP)) full = 128'(VOL_CAP);
      if (lo <= distance && distance <= h) begin
        coef = 128'd1 << (FRAC_BITS - 1);
        if (r != 0) coef = coef + ((128'(h - distance) << FRAC_BITS) / (128'(r) * 2));
        vol = (full * coef) >> FRAC_BITS;
      end else if (distance <= lo) begin
        vol = full;
      end
    end
    if (vol > 128'hFFFF_FFFF) begin
      res.bond_volume      = 32'hFFFF_FFFF;
      res.volume_saturated = 1'b1;
    end else begin
      res.bond_volume      = vol[31:0];
      res.volume_saturated = 1'b0;
    end
    return res;
  endfunction

  assign pending_o = expected_volumes.size();

  // Handshakes are sampled at the rising edge, before the block updates.
  always @(posedge clk_i or negedge rst_ni) begin
    volume_t                exp_v;
    logic signed [31:0]     c[3], n[3];
    if (!rst_ni) begin
      horizon_q    <= REG_ONE_RST;
      band_q       <= '0;
      grid_q       <= REG_ONE_RST;
      fail_count_o <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_volumes.size() == 0) begin
          $error("result item with no expectation: bond_volume %h", out_if.bond_volume);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = expected_volumes.pop_front();
          if (out_if.bond_volume !== exp_v.bond_volume ||
              out_if.volume_saturated !== exp_v.volume_saturated) begin
            fail_count_o <= fail_count_o + 1;
            if (out_if.bond_volume !== exp_v.bond_volume)
              $error("bond_volume: expected %h, actual %h",
                     exp_v.bond_volume, out_if.bond_volume);
            if (out_if.volume_saturated !== exp_v.volume_saturated)
              $error("volume_saturated: expected %b, actual %b",
                     exp_v.volume_saturated, out_if.volume_saturated);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        c = '{in_if.center_x, in_if.center_y, in_if.center_z};
        n = '{in_if.neighbor_x, in_if.neighbor_y, in_if.neighbor_z};
        expected_volumes.push_back(bond_volume_of(c, n));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.reg_index)
          REG_HORIZON: horizon_q <= cfg_if.wdata[REG_W-1:0];
          REG_BAND:    band_q    <= cfg_if.wdata[REG_W-1:0];
          REG_GRID:    grid_q    <= cfg_if.wdata[REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// Top of the bond partial volume testbench: drives bonds and register writes
// with random idling and gives the verdict. Depends on bpv_pkg, bpv_if.sv,
// bpv_checker and the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpv_pkg::*;

  localparam int unsigned      FRAC_BITS   = 16;
  localparam int               LATENCY     = 38 + 31 + FRAC_BITS;
  localparam int               CYCLE_LIMIT = 600000;
  localparam int               ITEMS_PER_PHASE = 110;
  localparam logic [IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [30:0]      REG_MAX     = 31'h7FFF_FFFF;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;

  // Idle percentages of the two sides; the hold request asks the receiver
  // for one long stall so the pipe fills and pushes back on the input.
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_request;
  bit   hold_done;

  // Shadow of horizon and band width, used only to aim random distances.
  longint cur_horizon;
  longint cur_band;

  bpv_in_if  in_if();
  bpv_out_if out_if();
  bpv_cfg_if cfg_if();

  bond_partial_volume_core #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  bpv_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .cfg_if       (cfg_if),
    .out_if       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: random ready, or a long stall of its own when requested.
  always @(negedge clk_i) begin
    if (hold_request && !hold_done) begin
      out_if.ready <= 1'b0;
      repeat (400) @(negedge clk_i);
      hold_done = 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one bond; valid stays high after acceptance until the next
  // falling edge decides whether another item or an idle cycle follows.
  task automatic send_bond(input logic [31:0] cx, cy, cz, nx, ny, nz);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.center_x   <= cx;
    in_if.center_y   <= cy;
    in_if.center_z   <= cz;
    in_if.neighbor_x <= nx;
    in_if.neighbor_y <= ny;
    in_if.neighbor_z <= nz;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until every expected result has arrived and the pipe has emptied,
  // so that registers can be changed safely.
  task automatic drain;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Loads a full setting. The cell volume is registered in bpv_cube and lags a
  // grid write, so a short pause follows before any bond is offered.
  task automatic configure(input logic [30:0] h, r, g);
    write_reg(REG_HORIZON, {1'($urandom_range(1)), h});
    write_reg(REG_BAND, {1'b0, r});
    write_reg(REG_GRID, {1'($urandom_range(1)), g});
    write_reg(REG_UNUSED, $urandom());
    cur_horizon = h;
    cur_band    = r;
    repeat (8) @(posedge clk_i);
  endtask

  // A random bond: mostly distances aimed near the horizon and band edge,
  // some spread over every scale, and some with fully random coordinates.
  task automatic send_random_bond;
    logic [31:0] c[3], n[3];
    longint      off[3];
    int          mode;
    int          shift;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) c[i] = $urandom();
    for (int i = 0; i < 3; i++) begin
      shift  = $urandom_range(31);
      off[i] = longint'($signed($urandom())) >>> shift;
    end
    if (mode < 5) begin
      // Along one axis, right around the horizon or the inner band edge.
      off[0] = (mode < 3 ? cur_horizon : cur_horizon - cur_band)
               + longint'($urandom_range(6)) - 3;
      if (off[0] < 0) off[0] = -off[0];
      if (off[0] > 64'h7FFF_FFFF) off[0] = 64'h7FFF_FFFF;
      if ($urandom_range(1)) off[0] = -off[0];
      off[1] = (mode == 4) ? 0 : longint'($urandom_range(3)) - 1;
      off[2] = 0;
    end else if (mode == 5) begin
      // Somewhere inside the band.
      off[0] = cur_horizon - longint'($urandom_range(cur_band > 0 ? 1000 : 0))
               * cur_band / 1000;
      if (off[0] < 0) off[0] = 0;
      if (off[0] > 64'h7FFF_FFFF) off[0] = 64'h7FFF_FFFF;
      off[1] = 0;
      off[2] = 0;
    end
    for (int i = 0; i < 3; i++) n[i] = (mode == 9) ? $urandom() : c[i] + off[i][31:0];
    send_bond(c[0], c[1], c[2], n[0], n[1], n[2]);
  endtask

  initial begin
    logic [30:0] h_set[8], r_set[8], g_set[8];
    rst_ni        = 1'b0;
    hold_request  = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 68;
    cur_horizon   = 65536;
    cur_band      = 0;
    in_if.valid      = 1'b0;
    in_if.center_x   = '0;
    in_if.center_y   = '0;
    in_if.center_z   = '0;
    in_if.neighbor_x = '0;
    in_if.neighbor_y = '0;
    in_if.neighbor_z = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = REG_HORIZON;
    cfg_if.wdata     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed bonds under the reset setting: coincident points, exactly on
    // the horizon (zero band width gives half volume), just outside it, and
    // a separation of 2^31 on one axis that lies beyond every horizon.
    send_bond(0, 0, 0, 0, 0, 0);
    send_bond(0, 0, 0, 32'h0001_0000, 0, 0);
    send_bond(0, 0, 0, 0, 32'hFFFF_0000, 0);
    send_bond(0, 0, 0, 0, 0, 32'h0001_0001);
    send_bond(32'h8000_0000, 0, 0, 0, 0, 0);
    send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    drain();

    // Band of 4 below a horizon of 10 with spacing 2: inside, band edges and
    // middle, on the horizon, and outside.
    configure(31'(10 << 16), 31'(4 << 16), 31'(2 << 16));
    send_bond(0, 0, 0, 32'(5 << 16), 0, 0);
    send_bond(0, 0, 0, 32'(6 << 16), 0, 0);
    send_bond(0, 0, 0, 32'(8 << 16), 0, 0);
    send_bond(0, 0, 0, 32'(6 << 16), 32'(8 << 16), 0);
    send_bond(0, 0, 0, 32'(6 << 16), 32'(8 << 16), 1);
    send_bond(32'h4000_0000, 0, 0, 32'hC000_0000, 0, 0);
    drain();

    // Band wider than the horizon, and the largest cell volume saturating.
    configure(31'(3 << 16), 31'(9 << 16), REG_MAX);
    send_bond(0, 0, 0, 0, 0, 0);
    send_bond(0, 0, 0, 32'(3 << 16), 0, 0);
    send_bond(0, 0, 0, 32'(3 << 16) + 1, 0, 0);
    drain();
    configure(REG_MAX, 31'd1, 31'd1);
    send_bond(0, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_bond(0, 0, 0, 32'h7FFF_FFFE, 0, 0);
    drain();

    h_set = '{31'd65536, 31'd0, REG_MAX, REG_MAX, 31'(10 << 16), 31'(5 << 16),
              31'(1 << 16), 31'($urandom())};
    r_set = '{31'd0, 31'd0, REG_MAX, 31'd0, 31'(3 << 16), 31'(20 << 16),
              31'd1, 31'($urandom_range(1 << 20))};
    g_set = '{31'd65536, 31'd0, REG_MAX, 31'd65536, 31'(2 << 16), 31'h0002_8000,
              REG_MAX, 31'($urandom_range(1 << 20))};

    for (int p = 0; p < 8; p++) begin
      configure(h_set[p], r_set[p], g_set[p]);
      // Idling schedule: sender light and receiver heavy, then swapped,
      // then both sides at full rate.
      if (p < 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 68;
      end else if (p < 6) begin
        send_idle_pct = 68;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 6 && k == 10) hold_request = 1'b1;
        // Mid-phase pause until every outstanding result has come back.
        if (p == 4 && k == ITEMS_PER_PHASE / 2) begin
          @(negedge clk_i);
          in_if.valid <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
        send_random_bond();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bpv_pkg.sv
design/bpv_if.sv
design/bpv_sqrt_cell.sv
design/bpv_div_cell.sv
design/bpv_cube.sv
design/bond_partial_volume_core.sv
test/bpv_checker.sv
test/tb_top.sv
